>>> hdl/brlt_pkg.sv
// Shared types and constants for the byte range lock table.
// No dependencies; brlt_ram, brlt_scan and byte_range_lock_table import this package.
`timescale 1ns / 1ps
`default_nettype none

package brlt_pkg;

    localparam int unsigned ADDR_W = 64;

    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

    typedef enum logic {
        OP_LOCK   = 1'b0,
        OP_UNLOCK = 1'b1
    } op_t;

    typedef enum logic {
        STATUS_DONE = 1'b0,
        STATUS_FULL = 1'b1
    } status_t;

    // One stored range, inclusive on both ends.
    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } entry_t;

    // Summary of one table sweep (depth independent part).
    typedef struct packed {
        logic [ADDR_W-1:0] merge_lo;
        logic [ADDR_W-1:0] merge_hi;
        logic              lo_found;
        logic [ADDR_W-1:0] lo_first;
        logic              hi_found;
        logic [ADDR_W-1:0] hi_last;
        logic [1:0]        free_cnt;
    } scan_sum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_WR0,
        ST_WR1,
        ST_DONE
    } state_t;

endpackage : brlt_pkg

`default_nettype wire

>>> hdl/brlt_req_if.sv
// Request channel of the byte range lock table: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface brlt_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] range_start;
    logic [63:0] range_length;

    modport source (output valid, output operation, output range_start,
                    output range_length, input ready);
    modport sink   (input valid, input operation, input range_start,
                    input range_length, output ready);
endinterface : brlt_req_if

`default_nettype wire

>>> hdl/brlt_rsp_if.sv
// Response channel of the byte range lock table: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface brlt_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [4:0]  range_count;
    logic [63:0] merged_start;
    logic [63:0] merged_end;

    modport source (output valid, output status, output range_count,
                    output merged_start, output merged_end, input ready);
    modport sink   (input valid, input status, input range_count,
                    input merged_start, input merged_end, output ready);
endinterface : brlt_rsp_if

`default_nettype wire

>>> hdl/brlt_ram.sv
// Range storage: one write port, one read port, registered read data.
// Depends on brlt_pkg for entry_t.
`timescale 1ns / 1ps
`default_nettype none

module brlt_ram #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
    input  brlt_pkg::entry_t             wr_data,
    input  wire                          rd_en,
    input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
    output brlt_pkg::entry_t             rd_data
);
    import brlt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : brlt_ram

`default_nettype wire

>>> hdl/brlt_scan.sv
// Sweep unit: takes one stored entry per cycle while ent_vld is high, marks
// overlaps, tracks the merged bounds, the split pieces and the first two reusable slots.
// Depends on brlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brlt_scan #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  wire  [63:0]                         tgt_first,
    input  wire  [63:0]                         tgt_last,
    input  wire                                 ent_vld,
    input  wire  [$clog2(DEPTH)-1:0]            ent_idx,
    input  wire                                 ent_live,
    input  brlt_pkg::entry_t                    ent,
    output brlt_pkg::scan_sum_t                 sum,
    output logic [DEPTH-1:0]                    hit_vec,
    output logic [$clog2(DEPTH+1)-1:0]          hit_cnt,
    output logic [$clog2(DEPTH)-1:0]            slot0,
    output logic [$clog2(DEPTH)-1:0]            slot1
);
    import brlt_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH+1);

    logic [1:0]         free_cnt_reg;
    logic               lo_found_reg;
    logic               hi_found_reg;
    logic [ADDR_W-1:0]  merge_lo_reg;
    logic [ADDR_W-1:0]  merge_hi_reg;
    logic [ADDR_W-1:0]  lo_first_reg;
    logic [ADDR_W-1:0]  hi_last_reg;
    logic [DEPTH-1:0]   hit_vec_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [IDX_W-1:0]   slot0_reg;
    logic [IDX_W-1:0]   slot1_reg;

    logic hit;
    logic cand;

    assign hit  = ent_live && (ent.first <= tgt_last) && (ent.last >= tgt_first);
    assign cand = !ent_live || hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_vec_reg  <= '0;
            hit_cnt_reg  <= '0;
            free_cnt_reg <= '0;
            lo_found_reg <= 1'b0;
            hi_found_reg <= 1'b0;
        end
        else if (start)
        begin
            hit_vec_reg  <= '0;
            hit_cnt_reg  <= '0;
            free_cnt_reg <= '0;
            lo_found_reg <= 1'b0;
            hi_found_reg <= 1'b0;
        end
        else if (ent_vld)
        begin
            if (hit)
            begin
                hit_vec_reg[ent_idx] <= 1'b1;
                hit_cnt_reg          <= hit_cnt_reg + CNT_W'(1);
                if (ent.first < tgt_first)
                begin
                    lo_found_reg <= 1'b1;
                end
                if ((ent.last > tgt_last) && (tgt_last != ALL_ONES))
                begin
                    hi_found_reg <= 1'b1;
                end
            end
            if (cand && (free_cnt_reg != 2'd2))
            begin
                free_cnt_reg <= free_cnt_reg + 2'd1;
            end
        end
    end

    // Payload side of the summary, no reset needed.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            merge_lo_reg <= tgt_first;
            merge_hi_reg <= tgt_last;
        end
        else if (ent_vld)
        begin
            if (hit)
            begin
                if (ent.first < merge_lo_reg)
                begin
                    merge_lo_reg <= ent.first;
                end
                if (ent.last > merge_hi_reg)
                begin
                    merge_hi_reg <= ent.last;
                end
                if (ent.first < tgt_first)
                begin
                    lo_first_reg <= ent.first;
                end
                if (ent.last > tgt_last)
                begin
                    hi_last_reg <= ent.last;
                end
            end
            if (cand)
            begin
                if (free_cnt_reg == 2'd0)
                begin
                    slot0_reg <= ent_idx;
                end
                else if (free_cnt_reg == 2'd1)
                begin
                    slot1_reg <= ent_idx;
                end
            end
        end
    end

    assign sum = '{merge_lo: merge_lo_reg,
                   merge_hi: merge_hi_reg,
                   lo_found: lo_found_reg,
                   lo_first: lo_first_reg,
                   hi_found: hi_found_reg,
                   hi_last:  hi_last_reg,
                   free_cnt: free_cnt_reg};
    assign hit_vec = hit_vec_reg;
    assign hit_cnt = hit_cnt_reg;
    assign slot0   = slot0_reg;
    assign slot1   = slot1_reg;

endmodule : brlt_scan

`default_nettype wire

>>> hdl/byte_range_lock_table.sv
// Byte range lock table. Holds up to TABLE_DEPTH disjoint inclusive byte
// ranges [start, end]. A lock request (operation 0) merges the requested range
// with every stored range it overlaps (ranges that only touch stay apart); an
// unlock request (operation 1) cuts the requested span out of every range it
// overlaps and keeps the pieces below and above it. A length of zero, or a
// start plus length past the top of the 64-bit space, runs the range to the
// all-ones offset. When the result would need more slots than the table has,
// the request is refused with status 1 and nothing changes. Every request
// gives one response: status, the range count afterwards, and the merged range
// (accepted lock) or the requested range (anything else). The table lives in a
// single-port-write, single-port-read RAM; each request sweeps all entries
// through it, one per cycle. From acceptance to response a request passes
// through setup, the sweep, a drain step for the last read, a decision, up to
// two RAM write-backs for new ranges, and the response load, which waits
// until the previous response has been taken. A new request is taken once
// the previous one has been loaded into the response register, even while
// that response still waits.
// No clearing pass after reset: per-entry valid bits gate every read.
// Depends on brlt_pkg, brlt_req_if, brlt_rsp_if, brlt_ram and brlt_scan.
`timescale 1ns / 1ps
`default_nettype none

module byte_range_lock_table #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    brlt_req_if.sink     req,
    brlt_rsp_if.source   rsp
);
    import brlt_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CX_W  = CNT_W + 5;

    // ---------------------------------------------------------------
    // Control and request capture
    // ---------------------------------------------------------------
    state_t             state_reg, state_next;

    op_t                op_reg;
    logic [63:0]        ts_reg;
    logic [63:0]        lenm1_reg;     // length - 1, valid when length != 0
    logic               lenz_reg;      // length was zero
    logic [63:0]        te_reg;        // inclusive end of the request

    logic [IDX_W-1:0]   idx_reg;       // sweep read address
    logic               dv_reg;        // RAM read data valid this cycle
    logic [IDX_W-1:0]   didx_reg;      // entry index of that read data

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               status_reg;
    logic [63:0]        rs_reg;
    logic [63:0]        re_reg;
    logic [1:0]         wr_cnt_reg;
    entry_t             wr0_reg;
    entry_t             wr1_reg;

    // response register
    logic               ov_reg;
    logic               o_status_reg;
    logic [4:0]         o_count_reg;
    logic [63:0]        o_start_reg;
    logic [63:0]        o_end_reg;

    logic               accept;
    logic               sweep_start;
    logic               load_out;
    logic               sweep_last;

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && (state_reg == ST_IDLE);
    assign sweep_start = (state_reg == ST_SCAN) && (idx_reg == '0);
    assign sweep_last  = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign load_out    = (state_reg == ST_DONE) && (!ov_reg || rsp.ready);

    // ---------------------------------------------------------------
    // Storage and sweep unit
    // ---------------------------------------------------------------
    entry_t             rd_data;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    entry_t             ram_wr_data;

    scan_sum_t          sum;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [CNT_W-1:0]   hit_cnt;
    logic [IDX_W-1:0]   slot0;
    logic [IDX_W-1:0]   slot1;

    brlt_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    brlt_scan #(
        .DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sweep_start),
        .tgt_first (ts_reg),
        .tgt_last  (te_reg),
        .ent_vld   (dv_reg),
        .ent_idx   (didx_reg),
        .ent_live  (valid_reg[didx_reg]),
        .ent       (rd_data),
        .sum       (sum),
        .hit_vec   (hit_vec),
        .hit_cnt   (hit_cnt),
        .slot0     (slot0),
        .slot1     (slot1)
    );

    // Write-back port: first new range goes to slot0, second to slot1.
    assign ram_wr_en   = (state_reg == ST_WR0) || (state_reg == ST_WR1);
    assign ram_wr_addr = (state_reg == ST_WR1) ? slot1 : slot0;
    assign ram_wr_data = (state_reg == ST_WR1) ? wr1_reg : wr0_reg;

    // ---------------------------------------------------------------
    // End of the request: start + length - 1, saturating at all ones
    // ---------------------------------------------------------------
    logic [64:0] end_sum;
    logic [63:0] te_calc;

    assign end_sum = {1'b0, ts_reg} + {1'b0, lenm1_reg};
    assign te_calc = (lenz_reg || end_sum[64]) ? ALL_ONES : end_sum[63:0];

    // ---------------------------------------------------------------
    // Decision after the sweep
    // ---------------------------------------------------------------
    logic [1:0]         need;          // slots the outcome occupies
    logic               full;
    logic [CNT_W-1:0]   count_new;
    entry_t             lo_piece;
    entry_t             hi_piece;

    assign lo_piece.first = sum.lo_first;
    assign lo_piece.last  = ts_reg - 64'd1;
    assign hi_piece.first = te_reg + 64'd1;
    assign hi_piece.last  = sum.hi_last;

    always_comb
    begin
        if (op_reg == OP_LOCK)
        begin
            need = 2'd1;
        end
        else
        begin
            need = {1'b0, sum.lo_found} + {1'b0, sum.hi_found};
        end
    end

    // free_cnt counts slots that are empty or about to be freed, capped at two
    assign full      = (sum.free_cnt < need);
    assign count_new = count_reg - hit_cnt + CNT_W'(need);

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (full || (need == 2'd0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WR0;
                end
            end
            ST_WR0:
            begin
                state_next = (wr_cnt_reg == 2'd2) ? ST_WR1 : ST_DONE;
            end
            ST_WR1:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            dv_reg     <= 1'b0;
            valid_reg  <= '0;
            count_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            dv_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_SCAN)
            begin
                idx_reg <= sweep_last ? '0 : idx_reg + IDX_W'(1);
            end
            if ((state_reg == ST_DECIDE) && !full)
            begin
                valid_reg <= valid_reg & ~hit_vec;
                count_reg <= count_new;
            end
            else if (state_reg == ST_WR0)
            begin
                valid_reg[slot0] <= 1'b1;
            end
            else if (state_reg == ST_WR1)
            begin
                valid_reg[slot1] <= 1'b1;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    logic [CX_W-1:0] count_wide;

    assign count_wide = CX_W'(count_reg);

    always_ff @(posedge clk)
    begin
        didx_reg <= idx_reg;
        if (accept)
        begin
            op_reg    <= op_t'(req.operation);
            ts_reg    <= req.range_start;
            lenm1_reg <= req.range_length - 64'd1;
            lenz_reg  <= (req.range_length == 64'd0);
        end
        if (state_reg == ST_SETUP)
        begin
            te_reg <= te_calc;
        end
        if (state_reg == ST_DECIDE)
        begin
            status_reg <= full ? STATUS_FULL : STATUS_DONE;
            wr_cnt_reg <= need;
            if ((op_reg == OP_LOCK) && !full)
            begin
                rs_reg <= sum.merge_lo;
                re_reg <= sum.merge_hi;
            end
            else
            begin
                rs_reg <= ts_reg;
                re_reg <= te_reg;
            end
            if (op_reg == OP_LOCK)
            begin
                wr0_reg.first <= sum.merge_lo;
                wr0_reg.last  <= sum.merge_hi;
            end
            else if (sum.lo_found)
            begin
                wr0_reg <= lo_piece;
            end
            else
            begin
                wr0_reg <= hi_piece;
            end
            wr1_reg <= hi_piece;
        end
        if (load_out)
        begin
            o_status_reg <= status_reg;
            o_count_reg  <= count_wide[4:0];
            o_start_reg  <= rs_reg;
            o_end_reg    <= re_reg;
        end
    end

    assign rsp.valid        = ov_reg;
    assign rsp.status       = o_status_reg;
    assign rsp.range_count  = o_count_reg;
    assign rsp.merged_start = o_start_reg;
    assign rsp.merged_end   = o_end_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // the range count always matches the valid bits between requests
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == count_reg))
        else $error("range count disagrees with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(TABLE_DEPTH)))
        else $error("range count beyond table depth");

    // a refused request leaves the table untouched
    a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECIDE) && full) |=> ($stable(valid_reg) && $stable(count_reg)))
        else $error("refused request changed the table");

    // write-back only follows an accepted decision
    a_write_after_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR0) |-> (($past(state_reg) == ST_DECIDE) && !$past(full)))
        else $error("write-back without an accepted decision");

endmodule : byte_range_lock_table

`default_nettype wire
